@@ rtl/core/mlqs_pkg.sv @@
// Package for the multilevel queue scheduler: sizes, status codes, table entry
// type and the class ordering function. No dependencies.
package mlqs_pkg;

    localparam int SLOTS     = 32;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int TIME_BITS = 16;
    localparam int CLASSES   = 5;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_LOADED   = 3'd0,
        ST_REJECTED = 3'd1,
        ST_SCHED    = 3'd2,
        ST_IDLE     = 3'd3,
        ST_ALL_DONE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CL_SYS = 3'd0,
        CL_IP  = 3'd1,
        CL_IEP = 3'd2,
        CL_BP  = 3'd3,
        CL_SP  = 3'd4
    } pclass_t;

    localparam logic [0:0] REG_QUANTUM = 1'b0;
    localparam logic [0:0] REG_PCOUNT  = 1'b1;

    typedef struct packed {
        logic [2:0]           pclass;
        logic [TIME_BITS-1:0] arrival;
        logic [7:0]           priority_key;
        logic [15:0]          orig_burst;
        logic [15:0]          remaining;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_UPDATE,
        S_OUT
    } state_t;

    // True when a beats b under the ordering of class c; equal keys never win.
    function automatic logic better(input logic [2:0] c, input entry_t a, input entry_t b);
        logic r;
        begin
            r = 1'b0;
            if (c == CL_SYS) begin
                if (a.priority_key != b.priority_key) r = a.priority_key < b.priority_key;
                else r = a.arrival < b.arrival;
            end
            else if (c == CL_IP || c == CL_IEP) begin
                r = a.arrival < b.arrival;
            end
            else begin
                if (a.orig_burst != b.orig_burst) r = a.orig_burst < b.orig_burst;
                else r = a.arrival < b.arrival;
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/core/mlqs_table.sv @@
// Process table memory for the multilevel queue scheduler: one write port and
// one registered read port, plus per-slot valid bits. Uses mlqs_pkg.
module mlqs_table
    import mlqs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic                 wr_set_valid,
    input  logic [SLOT_BITS-1:0] wr_addr,
    input  entry_t               wr_data,
    input  logic [SLOT_BITS-1:0] rd_addr,
    output entry_t               rd_data,
    output logic                 rd_valid,
    input  logic [SLOT_BITS-1:0] chk_addr,
    output logic                 chk_valid
);

    entry_t            mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else begin
            if (wr_en && wr_set_valid) valid_reg[wr_addr] <= 1'b1;
            rd_valid <= valid_reg[rd_addr];
        end
    end

    assign chk_valid = valid_reg[chk_addr];

endmodule

@@ rtl/core/multilevel_queue_scheduler.sv @@
// Top level of the multilevel queue scheduler. Holds the sequencer, the scan
// over the process table and the result register. Uses mlqs_pkg, mlqs_table.
//
// Usage: one input channel (in_valid/in_ready) carries items of mode, slot,
// process_class, arrival_tick, burst and priority_req. Mode 0 loads a process
// into a table slot, mode 1 advances one time tick. Each input item yields
// exactly one result item on the output channel (out_valid/out_ready) with
// status, run_slot, completed and the completion, turnaround and waiting times.
// Configuration (quantum, process_count) is written through cfg_we, cfg_index
// and cfg_data. The user must write it only while the block is idle; the block
// itself does not enforce this. The load step checks a load, writes it if it is
// accepted and registers its result. A tick reads all 32 slots one a cycle
// through the table's single read port, keeping for every class the best
// eligible slot; the pick step then picks the class and the update step writes
// back the winner's remaining burst and registers a scheduled result. With no
// eligible slot the pick step registers an idle or all done result instead. One
// item is in work at a time and the next is accepted the cycle after the result
// is taken. A stalled receiver holds the result and blocks input.
// Reset clears all slots to invalid, time to 0, class to system, the quantum
// count to 1, the completion count to 0, quantum to 4 and process_count to 0.
module multilevel_queue_scheduler
    import mlqs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [4:0]           slot,
    input  logic [2:0]           process_class,
    input  logic [15:0]          arrival_tick,
    input  logic [15:0]          burst,
    input  logic [7:0]           priority_req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [4:0]           run_slot,
    output logic                 completed,
    output logic [15:0]          finish_tick,
    output logic [15:0]          turnaround,
    output logic [15:0]          waiting,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [7:0]           cfg_data
);

    state_t state_reg, state_next;

    // Configuration.
    logic [7:0] quantum_reg;
    logic [5:0] pcount_reg;

    // Scheduler state.
    logic [TIME_BITS-1:0] time_reg;
    logic [2:0]           class_reg;
    logic [8:0]           qused_reg;
    logic [15:0]          ctotal_reg;

    // Captured input item.
    logic [SLOT_BITS-1:0] slot_reg;
    entry_t               item_reg;

    // Scan control and per-class best.
    logic [SLOT_BITS:0]   rd_cnt_reg;
    logic                 scan_v_reg;
    logic [SLOT_BITS-1:0] scan_addr_reg;
    logic [CLASSES-1:0]   found_reg;
    logic [SLOT_BITS-1:0] best_slot_reg [CLASSES];
    entry_t               best_reg [CLASSES];

    // Chosen winner.
    logic [SLOT_BITS-1:0] win_slot_reg;
    entry_t               win_reg;
    logic [2:0]           win_class_reg;

    // Output register.
    logic [2:0]  o_status_reg;
    logic [4:0]  o_slot_reg;
    logic        o_comp_reg;
    logic [15:0] o_ct_reg, o_tat_reg, o_wt_reg;
    logic        out_valid_reg;

    // Table ports.
    logic                 wr_en, wr_set_valid;
    logic [SLOT_BITS-1:0] wr_addr;
    entry_t               wr_data, rd_data;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 rd_valid, chk_valid;

    mlqs_table u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_set_valid (wr_set_valid),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .rd_valid     (rd_valid),
        .chk_addr     (slot_reg),
        .chk_valid    (chk_valid)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status          = o_status_reg;
    assign run_slot        = o_slot_reg;
    assign completed       = o_comp_reg;
    assign finish_tick     = o_ct_reg;
    assign turnaround      = o_tat_reg;
    assign waiting         = o_wt_reg;

    assign rd_addr = rd_cnt_reg[SLOT_BITS-1:0];

    // Rotation at the start of the tick, applied when the item is captured.
    logic [2:0] cls_rot;
    logic [8:0] qu_rot;
    always_comb
    begin
        cls_rot = class_reg;
        qu_rot  = qused_reg;
        if (qused_reg > {1'b0, quantum_reg}) begin
            qu_rot  = 9'd1;
            cls_rot = (class_reg == 3'(CLASSES - 1)) ? 3'd0 : class_reg + 3'd1;
        end
    end

    // Eligibility of the entry read in the previous cycle.
    logic rd_elig;
    assign rd_elig = scan_v_reg && rd_valid && (rd_data.remaining != 16'd0)
                     && (rd_data.arrival <= time_reg);

    // Class selection: first class at or after the current one with a candidate.
    logic [2:0] sel_class;
    logic       sel_skip;
    always_comb
    begin
        logic [3:0] sum;
        logic [2:0] c;
        sel_class = class_reg;
        sel_skip  = 1'b0;
        for (int k = CLASSES - 1; k >= 0; k--) begin
            sum = {1'b0, class_reg} + 4'(k);
            c   = (sum >= 4'(CLASSES)) ? 3'(sum - 4'(CLASSES)) : sum[2:0];
            if (found_reg[c]) begin
                sel_class = c;
                sel_skip  = (k != 0);
            end
        end
    end

    // Completion arithmetic on the winner after the decrement.
    logic [TIME_BITS-1:0] ct;
    logic [TIME_BITS-1:0] tat;
    logic [TIME_BITS:0]   wt_diff;
    logic [15:0]          rem_dec;
    assign rem_dec = win_reg.remaining - 16'd1;
    assign ct      = (time_reg < TIME_MAX) ? time_reg + 1'b1 : TIME_MAX;
    assign tat     = ct - win_reg.arrival;
    assign wt_diff = {1'b0, tat} - {1'b0, win_reg.orig_burst};

    always_comb
    begin
        state_next   = state_reg;
        wr_en        = 1'b0;
        wr_set_valid = 1'b0;
        wr_addr      = slot_reg;
        wr_data      = item_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid && in_ready) state_next = mode ? S_SCAN : S_LOAD;
            S_LOAD:   begin
                state_next = S_OUT;
                if (!(item_reg.pclass >= 3'(CLASSES) || item_reg.orig_burst == 16'd0
                      || chk_valid)) begin
                    wr_en        = 1'b1;
                    wr_set_valid = 1'b1;
                end
            end
            S_SCAN:   if (rd_cnt_reg == (SLOT_BITS+1)'(SLOTS) && !scan_v_reg)
                          state_next = S_PICK;
            S_PICK:   state_next = (found_reg != '0) ? S_UPDATE : S_OUT;
            S_UPDATE: begin
                state_next = S_OUT;
                wr_en      = 1'b1;
                wr_addr    = win_slot_reg;
                wr_data    = win_reg;
                wr_data.remaining = rem_dec;
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            quantum_reg   <= 8'd4;
            pcount_reg    <= 6'd0;
            time_reg      <= '0;
            class_reg     <= 3'd0;
            qused_reg     <= 9'd1;
            ctotal_reg    <= 16'd0;
            rd_cnt_reg    <= '0;
            scan_v_reg    <= 1'b0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == REG_QUANTUM) quantum_reg <= cfg_data;
                else pcount_reg <= cfg_data[5:0];
            end
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready && mode) begin
                        class_reg  <= cls_rot;
                        qused_reg  <= qu_rot;
                        rd_cnt_reg <= '0;
                        scan_v_reg <= 1'b0;
                        found_reg  <= '0;
                    end
                end
                S_LOAD: begin
                    out_valid_reg <= 1'b1;
                end
                S_SCAN: begin
                    if (rd_cnt_reg != (SLOT_BITS+1)'(SLOTS)) begin
                        rd_cnt_reg    <= rd_cnt_reg + 1'b1;
                        scan_v_reg    <= 1'b1;
                        scan_addr_reg <= rd_addr;
                    end
                    else begin
                        scan_v_reg <= 1'b0;
                    end
                    if (rd_elig && rd_data.pclass < 3'(CLASSES)) begin
                        if (!found_reg[rd_data.pclass] ||
                            better(rd_data.pclass, rd_data, best_reg[rd_data.pclass])) begin
                            found_reg[rd_data.pclass] <= 1'b1;
                        end
                    end
                end
                S_PICK: begin
                    if (found_reg == '0) begin
                        out_valid_reg <= 1'b1;
                        if (ctotal_reg != {10'd0, pcount_reg}) begin
                            if (time_reg < TIME_MAX) time_reg <= time_reg + 1'b1;
                        end
                    end
                    else begin
                        class_reg <= sel_class;
                        if (sel_skip) qused_reg <= 9'd1;
                    end
                end
                S_UPDATE: begin
                    out_valid_reg <= 1'b1;
                    if (rem_dec == 16'd0 && ctotal_reg != 16'hFFFF)
                        ctotal_reg <= ctotal_reg + 16'd1;
                    if (qused_reg < 9'd256) qused_reg <= qused_reg + 9'd1;
                    if (time_reg < TIME_MAX) time_reg <= time_reg + 1'b1;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready) begin
            slot_reg              <= slot;
            item_reg.pclass       <= process_class;
            item_reg.arrival      <= arrival_tick;
            item_reg.priority_key <= priority_req;
            item_reg.orig_burst   <= burst;
            item_reg.remaining    <= burst;
        end
        if (state_reg == S_SCAN && rd_elig && rd_data.pclass < 3'(CLASSES)) begin
            if (!found_reg[rd_data.pclass] ||
                better(rd_data.pclass, rd_data, best_reg[rd_data.pclass])) begin
                best_reg[rd_data.pclass]      <= rd_data;
                best_slot_reg[rd_data.pclass] <= scan_addr_reg;
            end
        end
        if (state_reg == S_PICK) begin
            win_class_reg <= sel_class;
            win_slot_reg  <= best_slot_reg[sel_class];
            win_reg       <= best_reg[sel_class];
        end
        if (state_reg == S_LOAD) begin
            o_status_reg <= (item_reg.pclass >= 3'(CLASSES) || item_reg.orig_burst == 16'd0
                             || chk_valid) ? ST_REJECTED : ST_LOADED;
            o_slot_reg <= '0;
            o_comp_reg <= 1'b0;
            o_ct_reg   <= '0;
            o_tat_reg  <= '0;
            o_wt_reg   <= '0;
        end
        if (state_reg == S_PICK && found_reg == '0) begin
            o_status_reg <= (ctotal_reg == {10'd0, pcount_reg}) ? ST_ALL_DONE : ST_IDLE;
            o_slot_reg <= '0;
            o_comp_reg <= 1'b0;
            o_ct_reg   <= '0;
            o_tat_reg  <= '0;
            o_wt_reg   <= '0;
        end
        if (state_reg == S_UPDATE) begin
            o_status_reg <= ST_SCHED;
            o_slot_reg   <= 5'(win_slot_reg);
            o_comp_reg   <= (rem_dec == 16'd0);
            o_ct_reg     <= (rem_dec == 16'd0) ? 16'(ct) : 16'd0;
            o_tat_reg    <= (rem_dec == 16'd0) ? 16'(tat) : 16'd0;
            o_wt_reg     <= (rem_dec == 16'd0 && !wt_diff[TIME_BITS])
                            ? 16'(wt_diff[TIME_BITS-1:0]) : 16'd0;
        end
    end

`ifndef SYNTH
    // A new item is never accepted while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !out_valid)
        else $error("item accepted while result pending");
    // The winner's class matches the selected class when it is written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> (win_class_reg == class_reg))
        else $error("winner class mismatch");
    // Time never goes backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (time_reg >= $past(time_reg)))
        else $error("time moved backward");
    // A scheduled result always comes from the update step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && (status == ST_SCHED) |-> $past(state_reg == S_UPDATE))
        else $error("scheduled result without update");
`endif

endmodule

@@ test/tb_multilevel_queue_scheduler.sv @@
// Self-checking testbench for multilevel_queue_scheduler: loads, ticks and
// configuration writes, each result checked against a built-in predictor.
// Depends on mlqs_pkg and the multilevel_queue_scheduler RTL.
module tb_multilevel_queue_scheduler;
    import mlqs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no item accepted or result taken before the run is declared
    // hung. It covers the receiver hold-off, a whole tick and config gaps.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        bit        mode;
        bit [4:0]  slot;
        bit [2:0]  pcls;
        bit [15:0] arr;
        bit [15:0] bur;
        bit [7:0]  prio;
    } job_t;

    typedef struct packed {
        status_t   status;
        bit [4:0]  run_slot;
        bit        completed;
        bit [15:0] ct;
        bit [15:0] tat;
        bit [15:0] wt;
    } verdict_t;

    // Scoreboard: keeps its own copy of the process table and scheduler state,
    // predicts the result of each accepted item and checks results in order.
    class sched_scoreboard;
        bit        valid [SLOTS];
        bit [2:0]  cls   [SLOTS];
        bit [15:0] arr   [SLOTS];
        bit [7:0]  prio  [SLOTS];
        bit [15:0] obur  [SLOTS];
        bit [15:0] rem   [SLOTS];
        bit [15:0] now;
        bit [2:0]  cur_cls;
        bit [8:0]  qused;
        bit [15:0] done_cnt;
        bit [7:0]  quantum;
        bit [5:0]  pcount;
        verdict_t  expected_q[$];
        int        mismatches;
        int        loads;
        int        ticks;

        function new();
            foreach (valid[i]) valid[i] = 0;
            now = 0;
            cur_cls = CL_SYS;
            qused = 1;
            done_cnt = 0;
            quantum = 4;
            pcount = 0;
            mismatches = 0;
            loads = 0;
            ticks = 0;
        endfunction

        function bit ready_to_run(int s);
            return valid[s] && rem[s] != 0 && arr[s] <= now;
        endfunction

        function bit class_ready(bit [2:0] c);
            for (int s = 0; s < SLOTS; s++)
                if (ready_to_run(s) && cls[s] == c) return 1;
            return 0;
        endfunction

        // True when slot a is served ahead of slot b in class c.
        function bit outranks(bit [2:0] c, int a, int b);
            if (c == CL_SYS) begin
                if (prio[a] != prio[b]) return prio[a] < prio[b];
                return arr[a] < arr[b];
            end
            if (c == CL_IP || c == CL_IEP) return arr[a] < arr[b];
            if (obur[a] != obur[b]) return obur[a] < obur[b];
            return arr[a] < arr[b];
        endfunction

        function void note_item(job_t j);
            verdict_t v;
            int       best;
            bit       any;
            bit [15:0] t;
            v = '{ST_LOADED, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0};
            best = -1;
            any = 0;
            if (!j.mode) begin
                if (j.pcls >= CLASSES || j.bur == 0 || valid[j.slot]) begin
                    v.status = ST_REJECTED;
                end
                else begin
                    valid[j.slot] = 1;
                    cls[j.slot] = j.pcls;
                    arr[j.slot] = j.arr;
                    prio[j.slot] = j.prio;
                    obur[j.slot] = j.bur;
                    rem[j.slot] = j.bur;
                    loads++;
                end
                expected_q.push_back(v);
                return;
            end
            ticks++;
            if (qused > quantum) begin
                qused = 1;
                cur_cls = (cur_cls == CL_SP) ? CL_SYS : 3'(cur_cls + 3'd1);
            end
            for (int s = 0; s < SLOTS; s++) if (ready_to_run(s)) any = 1;
            if (!any) begin
                if (done_cnt == {10'd0, pcount}) v.status = ST_ALL_DONE;
                else begin
                    v.status = ST_IDLE;
                    if (now != TIME_MAX) now++;
                end
                expected_q.push_back(v);
                return;
            end
            // Skip empty classes; every skip restarts the quantum count.
            while (!class_ready(cur_cls)) begin
                cur_cls = (cur_cls == CL_SP) ? CL_SYS : 3'(cur_cls + 3'd1);
                qused = 1;
            end
            for (int s = 0; s < SLOTS; s++)
                if (ready_to_run(s) && cls[s] == cur_cls)
                    if (best < 0 || outranks(cur_cls, s, best)) best = s;
            v.status = ST_SCHED;
            v.run_slot = 5'(best);
            rem[best]--;
            if (rem[best] == 0) begin
                t = (now != TIME_MAX) ? now + 16'd1 : TIME_MAX;
                v.completed = 1;
                v.ct = t;
                v.tat = t - arr[best];
                v.wt = (v.tat >= obur[best]) ? v.tat - obur[best] : 16'd0;
                if (done_cnt != 16'hFFFF) done_cnt++;
            end
            if (qused < 256) qused++;
            if (now != TIME_MAX) now++;
            expected_q.push_back(v);
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected, status %0d", got.status);
                return;
            end
            want = expected_q.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected st=%0d slot=%0d done=%0d ct=%0d tat=%0d ",
                              "wt=%0d, got st=%0d slot=%0d done=%0d ct=%0d tat=%0d wt=%0d"},
                        want.status, want.run_slot, want.completed, want.ct, want.tat,
                        want.wt, got.status, got.run_slot, got.completed, got.ct,
                        got.tat, got.wt);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [4:0]  slot;
    logic [2:0]  process_class;
    logic [15:0] arrival_tick;
    logic [15:0] burst;
    logic [7:0]  priority_req;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [4:0]  run_slot;
    logic        completed;
    logic [15:0] finish_tick;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [7:0]  cfg_data;

    sched_scoreboard sb = new();
    bit quiet;        // no random idling on either side while set
    bit hold_req;     // asks the receiver for one long hold-off
    int stall_cycles;

    multilevel_queue_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .slot(slot), .process_class(process_class),
        .arrival_tick(arrival_tick), .burst(burst), .priority_req(priority_req),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .run_slot(run_slot), .completed(completed),
        .finish_tick(finish_tick), .turnaround(turnaround), .waiting(waiting),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request so the
    // block fills up and stalls its input while the sender keeps offering.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    // Monitor: all values read here are the ones before this clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_item('{mode, slot, process_class, arrival_tick, burst, priority_req});
            if (out_valid && out_ready)
                sb.check_result('{status_t'(status), run_slot, completed,
                                  finish_tick, turnaround, waiting});
            if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("multilevel_queue_scheduler test failed");
                $finish;
            end
        end
    end

    // Offers one item and returns at the edge where it is accepted. A random
    // gap may come first; otherwise valid stays high from the previous item.
    task automatic send_item(job_t j);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= j.mode;
        slot <= j.slot;
        process_class <= j.pcls;
        arrival_tick <= j.arr;
        burst <= j.bur;
        priority_req <= j.prio;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic tick();
        send_item('{1'b1, 5'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom)});
    endtask

    task automatic load(bit [4:0] s, bit [2:0] c, bit [15:0] a, bit [15:0] b, bit [7:0] p);
        send_item('{1'b0, s, c, a, b, p});
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, bit [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_QUANTUM) sb.quantum = val;
        else sb.pcount = val[5:0];
    endtask

    // Random item: mostly ticks, some well-formed loads into free slots with
    // arrivals near the current time, and noise loads that may be malformed.
    task automatic random_item();
        int free_slots[$];
        int pick;
        bit [15:0] a;
        for (int s = 0; s < SLOTS; s++) if (!sb.valid[s]) free_slots.push_back(s);
        pick = $urandom_range(99);
        if (pick < 10 && free_slots.size() != 0)
        begin
            a = (sb.now > 16'hFFFF - 40) ? 16'hFFFF : 16'(sb.now + $urandom_range(0, 30));
            load(5'(free_slots[$urandom_range(0, free_slots.size() - 1)]),
                 3'($urandom_range(0, 4)), a, 16'($urandom_range(1, 12)), 8'($urandom));
        end
        else if (pick < 16)
        begin
            // Noise: any slot, any class code, burst possibly zero.
            load(5'($urandom), 3'($urandom), 16'($urandom),
                 $urandom_range(0, 1) ? 16'd0 : 16'($urandom), 8'($urandom));
        end
        else
        begin
            tick();
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        mode = 0;
        slot = 0;
        process_class = 0;
        arrival_tick = 0;
        burst = 0;
        priority_req = 0;
        cfg_we = 0;
        cfg_index = REG_QUANTUM;
        cfg_data = 0;
        quiet = 0;
        hold_req = 0;
        stall_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset configuration. An empty table with a process
        // count of zero reports all done right away.
        tick();
        load(0, CL_SYS, 0, 1, 8'hFF);
        load(0, CL_IP, 0, 5, 0);                 // slot already taken
        load(31, 3'd7, 0, 1, 0);                 // class code out of range
        load(30, 3'd5, 0, 1, 0);                 // first invalid class code
        load(29, CL_BP, 0, 0, 0);                // zero burst
        load(1, CL_IP, 0, 2, 8'h55);
        load(2, CL_IEP, 1, 1, 8'hAA);
        load(3, CL_BP, 0, 3, 0);
        load(6, CL_BP, 0, 3, 0);                 // equal keys, lower slot wins
        load(4, CL_SP, 0, 2, 8'h0F);
        load(5, CL_SP, 16'hFFFF, 16'hFFFF, 8'hF0); // never becomes eligible
        repeat (12) tick();
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_QUANTUM, 1);   write_reg(REG_PCOUNT, 32); end
                1: begin write_reg(REG_QUANTUM, 255); write_reg(REG_PCOUNT, 0);  end
                2: begin write_reg(REG_QUANTUM, 0);
                         write_reg(REG_PCOUNT, 8'($urandom_range(0, 32))); end
                3: begin write_reg(REG_QUANTUM, 8'($urandom_range(2, 8)));
                         write_reg(REG_PCOUNT, 8'(sb.done_cnt[5:0])); end
                default: begin write_reg(REG_QUANTUM, 3); write_reg(REG_PCOUNT, 32); end
            endcase
            quiet = (ph == 1);
            if (ph == 2) hold_req = 1;
            repeat (PHASE_ITEMS) random_item();
            // The sender pauses here until every expected result is back.
            drain();
        end
        quiet = 0;

        repeat (50) @(posedge clk);
        $display("Run covered %0d loads and %0d ticks with %0d completions over five settings.",
                 sb.loads, sb.ticks, sb.done_cnt);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("multilevel_queue_scheduler test passed");
        else
            $display("multilevel_queue_scheduler test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mlqs_pkg.sv
rtl/core/mlqs_table.sv
rtl/core/multilevel_queue_scheduler.sv
test/tb_multilevel_queue_scheduler.sv
